// ----- hw/rtl/glr_pkg.sv -----
// Shared types and constants for the grid line rasterizer.
package glr_pkg;

    localparam int COORD_W      = 5;
    localparam int FIELD_MIN    = -16;
    localparam int FIELD_MAX    = 15;
    localparam int MAX_CELLS    = 32;
    localparam int GRID_HALF_DEF = 16;

    // step counter must hold MAX_CELLS - 1
    localparam int STEP_W = $clog2(MAX_CELLS);

    typedef logic signed [COORD_W-1:0] coord_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
    } glr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;
    } glr_status_t;

endpackage

// ----- hw/rtl/glr_ctrl.sv -----
// Sequencer for the line walk: load cycle, then one cell per cycle.
module glr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  glr_pkg::glr_status_t status,
    output glr_pkg::glr_cmd_t   cmd,
    output logic                busy,
    output logic                cell_valid
);
    import glr_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   valid_reg;

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                    busy_next  = 1'b1;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.at_end)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            // every walk cycle produces one cell in the output register
            valid_reg <= (state_reg == ST_WALK);
        end
    end

    assign busy       = busy_reg;
    assign cell_valid = valid_reg;

endmodule

// ----- hw/rtl/glr_datapath.sv -----
// Coordinate clamp, deltas, error term and the stepping position registers.
module glr_datapath
#(
    parameter int GRID_HALF = glr_pkg::GRID_HALF_DEF
)
(
    input  logic                 clk,
    input  glr_pkg::glr_cmd_t    cmd,
    input  glr_pkg::coord_t      start_x,
    input  glr_pkg::coord_t      start_y,
    input  glr_pkg::coord_t      end_x,
    input  glr_pkg::coord_t      end_y,
    output glr_pkg::glr_status_t status,
    output glr_pkg::coord_t      cell_x,
    output glr_pkg::coord_t      cell_y,
    output logic                 is_last
);
    import glr_pkg::*;

    localparam int CLAMP_LO = (-GRID_HALF < FIELD_MIN) ? FIELD_MIN : -GRID_HALF;
    localparam int CLAMP_HI = (GRID_HALF - 1 > FIELD_MAX) ? FIELD_MAX : GRID_HALF - 1;
    localparam int DELTA_W  = COORD_W;       // |difference| fits field width
    localparam int ERR_W    = COORD_W + 2;   // err lies within -2*dy .. 2*dx
    localparam int E2_W     = ERR_W + 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_CELLS - 1);

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [E2_W-1:0]  e2_t;

    function automatic coord_t clamp(input coord_t v);
        coord_t r;
        r = v;
        if (int'(v) < CLAMP_LO)
            r = coord_t'(CLAMP_LO);
        else if (int'(v) > CLAMP_HI)
            r = coord_t'(CLAMP_HI);
        return r;
    endfunction

    function automatic logic [DELTA_W-1:0] abs_diff(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] d;
        d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        return d[COORD_W] ? DELTA_W'(-d) : DELTA_W'(d);
    endfunction

    coord_t              x_reg, y_reg, xe_reg, ye_reg;
    logic [DELTA_W-1:0]  dx_reg, dy_reg;
    logic                x_neg_reg, y_neg_reg;
    err_t                err_reg;
    logic [STEP_W-1:0]   n_reg;
    coord_t              cell_x_reg, cell_y_reg;
    logic                last_reg;

    coord_t              sx0, sy0, ex0, ey0;
    logic [DELTA_W-1:0]  dx0, dy0;
    e2_t                 e2;
    e2_t                 neg_dy;
    logic                move_x, move_y;
    logic                at_end;
    err_t                err_next;
    coord_t              x_next, y_next;

    always_comb
    begin
        sx0 = clamp(start_x);
        sy0 = clamp(start_y);
        ex0 = clamp(end_x);
        ey0 = clamp(end_y);
        dx0 = abs_diff(sx0, ex0);
        dy0 = abs_diff(sy0, ey0);
    end

    always_comb
    begin
        e2       = {err_reg, 1'b0};
        neg_dy   = -$signed({{(E2_W-DELTA_W){1'b0}}, dy_reg});
        move_x   = e2 > neg_dy;
        move_y   = e2 < $signed({{(E2_W-DELTA_W){1'b0}}, dx_reg});
        at_end   = ((x_reg == xe_reg) && (y_reg == ye_reg)) || (n_reg == LAST_STEP);
        err_next = err_reg
                   - (move_x ? $signed({{(ERR_W-DELTA_W){1'b0}}, dy_reg}) : err_t'(0))
                   + (move_y ? $signed({{(ERR_W-DELTA_W){1'b0}}, dx_reg}) : err_t'(0));
        x_next   = move_x ? (x_neg_reg ? x_reg - coord_t'(1) : x_reg + coord_t'(1)) : x_reg;
        y_next   = move_y ? (y_neg_reg ? y_reg - coord_t'(1) : y_reg + coord_t'(1)) : y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= sx0;
            y_reg     <= sy0;
            xe_reg    <= ex0;
            ye_reg    <= ey0;
            dx_reg    <= dx0;
            dy_reg    <= dy0;
            x_neg_reg <= !(ex0 > sx0);
            y_neg_reg <= !(ey0 > sy0);
            err_reg   <= $signed({{(ERR_W-DELTA_W){1'b0}}, dx0})
                         - $signed({{(ERR_W-DELTA_W){1'b0}}, dy0});
            n_reg     <= '0;
        end
        else if (cmd.step)
        begin
            if (at_end)
            begin
                cell_x_reg <= xe_reg;
                cell_y_reg <= ye_reg;
                last_reg   <= 1'b1;
            end
            else
            begin
                cell_x_reg <= x_reg;
                cell_y_reg <= y_reg;
                last_reg   <= 1'b0;
                x_reg      <= x_next;
                y_reg      <= y_next;
                err_reg    <= err_next;
                n_reg      <= n_reg + STEP_W'(1);
            end
        end
    end

    assign status.at_end = at_end;
    assign cell_x        = cell_x_reg;
    assign cell_y        = cell_y_reg;
    assign is_last       = last_reg;

endmodule

// ----- hw/rtl/grid_line_rasterizer_unit.sv -----
// Top level of the grid line rasterizer: Bresenham walk from start cell to end cell.
//
//  Channel   Handshake            Payload
//  request   start & !busy        start_x, start_y, end_x, end_y
//  cell      cell_valid (1 cyc)   cell_x, cell_y, is_last
//
// A load, then one cell per cycle: max(|dx|, |dy|) + 1 cells, so a
// line yields 1 to 32 cells; the walk register loop in glr_datapath sets this.
// busy drops in the cycle the end cell is shown, so the next request can be
// taken then. Cells cannot be held off by the receiver.
// Reset clears the sequencer only; payload registers are not reset.
module grid_line_rasterizer_unit
#(
    parameter int GRID_HALF = glr_pkg::GRID_HALF_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  glr_pkg::coord_t start_x,
    input  glr_pkg::coord_t start_y,
    input  glr_pkg::coord_t end_x,
    input  glr_pkg::coord_t end_y,
    output logic            cell_valid,
    output glr_pkg::coord_t cell_x,
    output glr_pkg::coord_t cell_y,
    output logic            is_last
);
    import glr_pkg::*;

    glr_cmd_t    cmd;
    glr_status_t status;

    glr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .cell_valid (cell_valid)
    );

    glr_datapath
    #(
        .GRID_HALF (GRID_HALF)
    )
    u_datapath
    (
        .clk     (clk),
        .cmd     (cmd),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .status  (status),
        .cell_x  (cell_x),
        .cell_y  (cell_y),
        .is_last (is_last)
    );

    // accepted request starts a walk
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // first cell is shown in the cycle after busy rises
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |=> cell_valid)
        else $error("no cell after load cycle");

    // end cell closes the walk, any other cell keeps it open
    assert property (@(posedge clk) disable iff (!rst_n) (cell_valid && is_last) |-> !busy)
        else $error("busy still high on end cell");

    assert property (@(posedge clk) disable iff (!rst_n) (cell_valid && !is_last) |-> busy)
        else $error("walk ended before end cell");

endmodule
